FILE: design/assert_macros.svh
// Assertion macros shared by the RTL of the range generator.
// No dependencies; files that assert include this header by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define XRG_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define XRG_ASSERT_NEXT(lbl, clk, rst_n, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

FILE: design/xrg_pkg.sv
// Package of the xorshift128+ range generator: widths, codes, state type
// and the generator step. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package xrg_pkg;

  // Bits of the draw kept in the unit fraction (16 to 32).
  localparam int unsigned FRACTION_BITS = 32;

  localparam int unsigned WordWidth    = 64;
  localparam int unsigned HalfWidth    = 32;
  localparam int unsigned ApbAddrWidth = 4;
  localparam int unsigned ApbDataWidth = 64;
  // Address bit that selects between the two 64-bit seed registers.
  localparam int unsigned RegSelBit    = 3;

  localparam int unsigned ShiftLeft   = 23;
  localparam int unsigned ShiftRightX = 17;
  localparam int unsigned ShiftRightY = 26;

  localparam logic [WordWidth-1:0] SeedLowReset  = 64'd1;
  localparam logic [WordWidth-1:0] SeedHighReset = 64'd2;
  localparam logic [WordWidth-1:0] ZeroSeedFill  = 64'h9E37_79B9_7F4A_7C15;

  localparam logic [HalfWidth-1:0] FracMask = 32'hFFFF_FFFF << (HalfWidth - FRACTION_BITS);

  localparam int unsigned DivSteps     = WordWidth;
  localparam int unsigned MulSteps     = HalfWidth;
  localparam int unsigned StepCntWidth = $clog2(DivSteps);

  typedef enum logic [1:0] {
    CmdRaw        = 2'd0,
    CmdIntRange   = 2'd1,
    CmdUnitFrac   = 2'd2,
    CmdFixedRange = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    StIdle,
    StSetup,
    StDivide,
    StMultiply,
    StFinish
  } state_e;

  typedef enum logic {
    RegSeedLow  = 1'b0,
    RegSeedHigh = 1'b1
  } reg_sel_e;

  typedef struct packed {
    logic [WordWidth-1:0] word_a;
    logic [WordWidth-1:0] word_b;
  } rng_state_t;

  // Load both words from the seeds; an all-zero seed takes the fill constant.
  function automatic rng_state_t seed_state(input logic [WordWidth-1:0] seed_lo,
                                            input logic [WordWidth-1:0] seed_hi);
    rng_state_t s;
    if ((seed_lo == '0) && (seed_hi == '0)) begin
      s.word_a = ZeroSeedFill;
      s.word_b = ZeroSeedFill;
    end else begin
      s.word_a = seed_lo;
      s.word_b = seed_hi;
    end
    return s;
  endfunction

  // One xorshift128+ state step.
  function automatic rng_state_t advance(input rng_state_t cur);
    rng_state_t           nxt;
    logic [WordWidth-1:0] x;
    x          = cur.word_a ^ (cur.word_a << ShiftLeft);
    nxt.word_a = cur.word_b;
    nxt.word_b = x ^ cur.word_b ^ (x >> ShiftRightX) ^ (cur.word_b >> ShiftRightY);
    return nxt;
  endfunction

endpackage

`default_nettype wire

FILE: design/xrg_req_if.sv
// Request channel of the range generator: command and bounds.
// Depends on xrg_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface xrg_req_if;
  import xrg_pkg::*;

  logic               valid;
  logic               ready;
  cmd_e               cmd;
  logic signed [31:0] range_low;
  logic signed [31:0] range_high;

  modport source (output valid, cmd, range_low, range_high, input ready);
  modport sink   (input valid, cmd, range_low, range_high, output ready);
endinterface

`default_nettype wire

FILE: design/xrg_rsp_if.sv
// Result channel of the range generator: draw, ranged value, fraction, flag.
// Depends on xrg_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface xrg_rsp_if;
  import xrg_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [WordWidth-1:0] raw_value;
  logic signed [31:0]   scaled_value;
  logic [HalfWidth-1:0] unit_fraction;
  logic                 span_error;

  modport source (output valid, raw_value, scaled_value, unit_fraction, span_error,
                  input ready);
  modport sink   (input valid, raw_value, scaled_value, unit_fraction, span_error,
                  output ready);
endinterface

`default_nettype wire

FILE: design/xorshift128p_range_generator_top.sv
// xorshift128+ range generator (shifts 23, 17, 26). Each accepted request makes
// one draw, raw = new word_b + old word_b, and returns one result transaction
// with the raw draw, the top FRACTION_BITS bits as a Q0.32 fraction, and a
// ranged value picked by cmd: integer range low + raw mod (high-low+1) with a
// span error flag when that span wraps to zero, or fixed range
// low + frac*(high-low) on Q16.16 bounds. Raw and fraction draws and a zero span
// go from setup straight to the finish step; a fixed range first runs a
// bit-serial 32-step shift-add multiplier, and an integer range a 64-step
// restoring divider that retires one remainder bit per cycle. One request is
// in work at a time; the finished result sits in an output register, so a new
// request is taken while the previous result still waits. Seeds live in two
// 64-bit APB registers at byte addresses 0 and 8; writing either reloads both
// state words (an all-zero seed loads a fixed nonzero constant). Write seeds
// only while the block is idle.
// Depends on xrg_pkg, xrg_req_if, xrg_rsp_if and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module xorshift128p_range_generator_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  xrg_req_if.sink                           req_i,
  xrg_rsp_if.source                         rsp_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [xrg_pkg::ApbAddrWidth-1:0]  paddr,
  input  logic [xrg_pkg::ApbDataWidth-1:0]  pwdata,
  output logic [xrg_pkg::ApbDataWidth-1:0]  prdata,
  output logic                              pready
);
  import xrg_pkg::*;

  // Configuration registers and generator state
  logic [WordWidth-1:0] seed_low_q, seed_low_d;
  logic [WordWidth-1:0] seed_high_q, seed_high_d;
  rng_state_t           rng_q, rng_d;
  logic                 cfg_write;
  reg_sel_e             reg_sel;

  // Control
  state_e                  state_q, state_d;
  logic [StepCntWidth-1:0] cnt_q, cnt_d;
  logic                    req_accept;
  logic                    out_load;

  // Working registers of one transaction
  cmd_e                 cmd_q;
  logic signed [31:0]   lo_q, hi_q;
  logic [WordWidth-1:0] raw_q, raw_d;
  logic [WordWidth-1:0] span_q;
  logic                 span_zero_q;
  logic [WordWidth-1:0] dvd_q;
  logic [WordWidth-1:0] rem_q;
  logic [HalfWidth-1:0] mag_q;
  logic                 neg_q;
  logic [HalfWidth-1:0] mplr_q;
  logic [WordWidth-1:0] acc_q;
  rng_state_t           rng_next;

  // Datapath terms
  logic [WordWidth:0]   div_shift;
  logic [WordWidth:0]   div_diff;
  logic [HalfWidth:0]   mul_sum;
  logic                 span_zero_d;
  logic [HalfWidth-1:0] frac_d;
  logic [31:0]          scaled_d;

  // Output register
  logic                 rsp_valid_q;
  logic [WordWidth-1:0] rsp_raw_q;
  logic [31:0]          rsp_scaled_q;
  logic [HalfWidth-1:0] rsp_frac_q;
  logic                 rsp_err_q;

  // ---------------------------------------------------------------------------
  // APB seed registers: zero wait states, bit 3 of paddr selects the register.
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_sel   = reg_sel_e'(paddr[RegSelBit]);

  always_comb begin
    unique case (reg_sel)
      RegSeedLow:  prdata = seed_low_q;
      RegSeedHigh: prdata = seed_high_q;
      default:     prdata = '0;
    endcase
  end

  // Next seeds and state words: a seed write reloads both words from the
  // updated seed pair, an accepted request advances the generator one step.
  assign rng_next = advance(rng_q);
  assign raw_d    = rng_next.word_b + rng_q.word_b;

  always_comb begin
    seed_low_d  = seed_low_q;
    seed_high_d = seed_high_q;
    rng_d       = rng_q;
    if (cfg_write) begin
      if (reg_sel == RegSeedLow) begin
        seed_low_d = pwdata;
      end else begin
        seed_high_d = pwdata;
      end
      rng_d = seed_state(seed_low_d, seed_high_d);
    end else if (req_accept) begin
      rng_d = rng_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_low_q  <= SeedLowReset;
      seed_high_q <= SeedHighReset;
      rng_q       <= seed_state(SeedLowReset, SeedHighReset);
    end else begin
      seed_low_q  <= seed_low_d;
      seed_high_q <= seed_high_d;
      rng_q       <= rng_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  // Zero span: high - low + 1 wraps to zero only when high + 1 equals low.
  assign span_zero_d = ({hi_q[31], hi_q} + 33'd1) == {lo_q[31], lo_q};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (req_i.valid) state_d = StSetup;
      end
      StSetup: begin
        case (cmd_q) inside
          CmdIntRange:          state_d = span_zero_d ? StFinish : StDivide;
          CmdFixedRange:        state_d = StMultiply;
          CmdRaw, CmdUnitFrac:  state_d = StFinish;
          default:              state_d = StFinish;
        endcase
      end
      StDivide: begin
        if (cnt_q == StepCntWidth'(DivSteps - 1)) state_d = StFinish;
      end
      StMultiply: begin
        if (cnt_q == StepCntWidth'(MulSteps - 1)) state_d = StFinish;
      end
      StFinish: begin
        if (!rsp_valid_q || rsp_o.ready) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    req_i.ready = 1'b0;
    out_load    = 1'b0;
    cnt_d       = cnt_q;
    unique case (state_q)
      StIdle:     req_i.ready = 1'b1;
      StSetup:    cnt_d = '0;
      StDivide:   cnt_d = cnt_q + 1'b1;
      StMultiply: cnt_d = cnt_q + 1'b1;
      StFinish:   out_load = !rsp_valid_q || rsp_o.ready;
      default:    cnt_d = '0;
    endcase
  end

  assign req_accept = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Serial datapath
  // ---------------------------------------------------------------------------
  // Restoring division: shift one dividend bit into the remainder per cycle,
  // subtract the span whenever it fits.
  assign div_shift = {rem_q, dvd_q[WordWidth-1]};
  assign div_diff  = div_shift - {1'b0, span_q};

  // Shift-add multiply, multiplier LSB first; the product settles in acc_q.
  assign mul_sum = {1'b0, acc_q[WordWidth-1:HalfWidth]}
                 + {1'b0, (mplr_q[0] ? mag_q : {HalfWidth{1'b0}})};

  assign frac_d = raw_q[WordWidth-1:HalfWidth] & FracMask;

  always_ff @(posedge clk_i) begin
    if (req_accept) begin
      cmd_q <= req_i.cmd;
      lo_q  <= req_i.range_low;
      hi_q  <= req_i.range_high;
      raw_q <= raw_d;
    end
    unique case (state_q)
      StSetup: begin
        span_q      <= {{32{hi_q[31]}}, hi_q} - {{32{lo_q[31]}}, lo_q} + 64'd1;
        span_zero_q <= span_zero_d;
        dvd_q       <= raw_q;
        rem_q       <= '0;
        // Magnitude of high - low always fits 32 bits.
        neg_q       <= hi_q < lo_q;
        mag_q       <= (hi_q < lo_q) ? HalfWidth'(lo_q - hi_q) : HalfWidth'(hi_q - lo_q);
        mplr_q      <= frac_d;
        acc_q       <= '0;
      end
      StDivide: begin
        rem_q <= div_diff[WordWidth] ? div_shift[WordWidth-1:0] : div_diff[WordWidth-1:0];
        dvd_q <= {dvd_q[WordWidth-2:0], 1'b0};
      end
      StMultiply: begin
        acc_q  <= {mul_sum, acc_q[HalfWidth-1:1]};
        mplr_q <= {1'b0, mplr_q[HalfWidth-1:1]};
      end
      default: begin
        acc_q <= acc_q;
      end
    endcase
  end

  // Ranged value: a negative difference rounds the scaled step toward minus
  // infinity, so subtract the ceiling of the product's upper half.
  always_comb begin
    case (cmd_q) inside
      CmdIntRange: begin
        scaled_d = span_zero_q ? lo_q : lo_q + rem_q[31:0];
      end
      CmdFixedRange: begin
        scaled_d = neg_q ? lo_q - acc_q[WordWidth-1:HalfWidth]
                           - {{(HalfWidth-1){1'b0}}, |acc_q[HalfWidth-1:0]}
                         : lo_q + acc_q[WordWidth-1:HalfWidth];
      end
      CmdRaw, CmdUnitFrac: begin
        scaled_d = '0;
      end
      default: begin
        scaled_d = '0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Output register: hold the result until the sink takes the transaction.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (out_load) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      rsp_raw_q    <= raw_q;
      rsp_scaled_q <= scaled_d;
      rsp_frac_q   <= frac_d;
      rsp_err_q    <= (cmd_q == CmdIntRange) && span_zero_q;
    end
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.raw_value     = rsp_raw_q;
  assign rsp_o.scaled_value  = rsp_scaled_q;
  assign rsp_o.unit_fraction = rsp_frac_q;
  assign rsp_o.span_error    = rsp_err_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `XRG_ASSERT(a_state_nonzero, clk_i, rst_ni,
    (rng_q.word_a != '0) || (rng_q.word_b != '0), "generator state went all zero")
  `XRG_ASSERT(a_rem_below_span, clk_i, rst_ni,
    (state_q == StDivide) |-> (rem_q < span_q), "remainder not below span")
  `XRG_ASSERT_NEXT(a_accept_setup, clk_i, rst_ni,
    req_accept, (state_q == StSetup), "accepted request did not start setup")
  `XRG_ASSERT_NEXT(a_load_result, clk_i, rst_ni,
    out_load, (rsp_valid_q && (state_q == StIdle)), "finished result not held")

endmodule

`default_nettype wire

FILE: dv/tb_xorshift128p_range_generator_top.sv
// Testbench of the xorshift128+ range generator: directed and random draws, every
// result checked field by field against a cycle-free model or typed-in values.
// Depends on xrg_pkg, xrg_req_if, xrg_rsp_if and xorshift128p_range_generator_top.
`timescale 1ns / 1ps

module tb_xorshift128p_range_generator_top;
  import xrg_pkg::*;

  // Generator constants of the draw.
  localparam int unsigned XS_LEFT    = 23;
  localparam int unsigned XS_RIGHT_X = 17;
  localparam int unsigned XS_RIGHT_Y = 26;
  localparam logic [63:0] ZERO_SEED_WORD = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [31:0] FRAC_KEEP = 32'hFFFF_FFFF << (32 - FRACTION_BITS);

  // Seed registers sit 8 bytes apart.
  localparam logic [ApbAddrWidth-1:0] SEED_LOW_ADDR  = ApbAddrWidth'(8 * RegSeedLow);
  localparam logic [ApbAddrWidth-1:0] SEED_HIGH_ADDR = ApbAddrWidth'(8 * RegSeedHigh);

  localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;

  localparam int DRAIN_CYCLES  = 80;
  localparam int MAX_PRINTS    = 40;
  localparam int NUM_ROWS      = 20;

  typedef struct packed {
    logic [63:0]        raw;
    logic signed [31:0] scaled;
    logic [31:0]        frac;
    logic               err;
  } draw_result_t;

  // One request; pin_draw fixes raw and fraction, pin_range fixes scaled and error.
  typedef struct packed {
    cmd_e               cmd;
    logic signed [31:0] range_low;
    logic signed [31:0] range_high;
    logic               pin_draw;
    logic               pin_range;
    draw_result_t       pinned;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [ApbAddrWidth-1:0] paddr;
  logic [ApbDataWidth-1:0] pwdata;
  logic [ApbDataWidth-1:0] prdata;
  logic                    pready;

  xrg_req_if req_bus ();
  xrg_rsp_if rsp_bus ();

  xorshift128p_range_generator_top DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_bus),
    .rsp_o   (rsp_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Model state: seed registers and the two generator words.
  logic [63:0] seed_lo_q;
  logic [63:0] seed_hi_q;
  logic [63:0] gen_word_a;
  logic [63:0] gen_word_b;

  draw_result_t pending_draws[$];
  int           mismatch_count;
  int           send_idle_pct;
  int           recv_idle_pct;
  int           stall_left;

  // Directed draws right after reset (seeds 1 and 2). The first draw, edge
  // ranges with a span of zero, single-value ranges and the zero ranged value of
  // raw and fraction draws are typed in; the rest come from the model.
  stim_row_t directed_rows [0:NUM_ROWS-1] = '{
    '{CmdRaw,        32'sd0,       32'sd0,       1'b1, 1'b1,
      '{64'h0000_0000_0080_0045, 32'sd0, 32'd0, 1'b0}},
    '{CmdIntRange,   32'sd5,       32'sd4,       1'b0, 1'b1, '{64'd0, 32'sd5, 32'd0, 1'b1}},
    '{CmdIntRange,   INT_MAX,      INT_MAX - 1,  1'b0, 1'b1, '{64'd0, INT_MAX, 32'd0, 1'b1}},
    '{CmdIntRange,   32'sd0,       -32'sd1,      1'b0, 1'b1, '{64'd0, 32'sd0, 32'd0, 1'b1}},
    '{CmdIntRange,   INT_MIN,      INT_MAX,      1'b0, 1'b0, '0},
    '{CmdIntRange,   INT_MAX,      INT_MIN,      1'b0, 1'b0, '0},
    '{CmdIntRange,   32'sd7,       32'sd7,       1'b0, 1'b1, '{64'd0, 32'sd7, 32'd0, 1'b0}},
    '{CmdIntRange,   INT_MIN,      INT_MIN,      1'b0, 1'b1, '{64'd0, INT_MIN, 32'd0, 1'b0}},
    '{CmdIntRange,   -32'sd10,     32'sd10,      1'b0, 1'b0, '0},
    '{CmdUnitFrac,   -32'sd1,      -32'sd1,      1'b0, 1'b1, '{64'd0, 32'sd0, 32'd0, 1'b0}},
    '{CmdRaw,        INT_MIN,      INT_MAX,      1'b0, 1'b1, '{64'd0, 32'sd0, 32'd0, 1'b0}},
    '{CmdFixedRange, 32'sh0003_0000, 32'sh0003_0000, 1'b0, 1'b1,
      '{64'd0, 32'sh0003_0000, 32'd0, 1'b0}},
    '{CmdFixedRange, INT_MIN,      INT_MAX,      1'b0, 1'b0, '0},
    '{CmdFixedRange, INT_MAX,      INT_MIN,      1'b0, 1'b0, '0},
    '{CmdFixedRange, 32'shFFFE_8000, 32'sh0002_4000, 1'b0, 1'b0, '0},
    '{CmdFixedRange, 32'sd5,       32'sd4,       1'b0, 1'b0, '0},
    '{CmdUnitFrac,   INT_MAX,      32'sd0,       1'b0, 1'b0, '0},
    '{CmdIntRange,   -32'sd1,      INT_MIN,      1'b0, 1'b0, '0},
    '{CmdIntRange,   32'sd0,       32'sd1,       1'b0, 1'b0, '0},
    '{CmdFixedRange, INT_MIN,      INT_MIN,      1'b0, 1'b1, '{64'd0, INT_MIN, 32'd0, 1'b0}}
  };

  // 12 ns clock.
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Reload both generator words from the seeds; all-zero seeds take the fill word.
  function automatic void reload_words();
    if ((seed_lo_q == 64'd0) && (seed_hi_q == 64'd0)) begin
      gen_word_a = ZERO_SEED_WORD;
      gen_word_b = ZERO_SEED_WORD;
    end else begin
      gen_word_a = seed_lo_q;
      gen_word_b = seed_hi_q;
    end
  endfunction

  // Advance the generator one draw and shape the draw as cmd asks.
  function automatic draw_result_t predict_draw(input cmd_e cmd,
                                                input logic signed [31:0] range_low,
                                                input logic signed [31:0] range_high);
    draw_result_t r;
    logic [63:0]  old_a;
    logic [63:0]  old_b;
    logic [63:0]  mixed;
    logic [63:0]  low_ext;
    logic [63:0]  high_ext;
    logic [63:0]  span;
    logic [63:0]  diff;
    logic [63:0]  mag;
    logic [63:0]  prod;
    logic [63:0]  offset;
    logic [63:0]  sum;
    old_a      = gen_word_a;
    old_b      = gen_word_b;
    mixed      = old_a ^ (old_a << XS_LEFT);
    gen_word_a = old_b;
    gen_word_b = mixed ^ old_b ^ (mixed >> XS_RIGHT_X) ^ (old_b >> XS_RIGHT_Y);
    r.raw      = gen_word_b + old_b;
    r.frac     = r.raw[63:32] & FRAC_KEEP;
    r.scaled   = '0;
    r.err      = 1'b0;
    low_ext    = {{32{range_low[31]}}, range_low};
    high_ext   = {{32{range_high[31]}}, range_high};
    case (cmd)
      CmdIntRange: begin
        // Span in 64 bits; a reversed range wraps to a huge span and stays.
        span = high_ext - low_ext + 64'd1;
        if (span == 64'd0) begin
          r.err    = 1'b1;
          r.scaled = range_low;
        end else begin
          sum      = low_ext + (r.raw % span);
          r.scaled = sum[31:0];
        end
      end
      CmdFixedRange: begin
        // Scale the magnitude, floor toward minus infinity on a negative span.
        diff = high_ext - low_ext;
        mag  = diff[63] ? (64'd0 - diff) : diff;
        prod = mag * {32'd0, r.frac};
        if (diff[63]) begin
          offset = 64'd0 - ((prod + 64'h0000_0000_FFFF_FFFF) >> 32);
        end else begin
          offset = prod >> 32;
        end
        sum      = low_ext + offset;
        r.scaled = sum[31:0];
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] extreme_bound();
    case ($urandom_range(0, 4))
      0:       return INT_MIN;
      1:       return INT_MAX;
      2:       return -32'sd1;
      3:       return 32'sd1;
      default: return 32'sd0;
    endcase
  endfunction

  // Random request: full-width bounds, narrow ranges, zero spans, reversed
  // ranges, extremes and Q16.16 ranges.
  function automatic stim_row_t random_row();
    stim_row_t row;
    int        base;
    row     = '0;
    row.cmd = cmd_e'($urandom_range(0, 3));
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        row.range_low  = $urandom;
        row.range_high = $urandom;
      end
      3, 4: begin
        base           = int'($urandom_range(0, 2000)) - 1000;
        row.range_low  = base;
        row.range_high = base + int'($urandom_range(0, 100));
      end
      5: begin
        row.range_low  = $urandom;
        row.range_high = row.range_low - 32'sd1;
      end
      6: begin
        row.range_low  = $urandom;
        row.range_high = row.range_low;
      end
      7: begin
        row.range_low  = extreme_bound();
        row.range_high = extreme_bound();
      end
      8: begin
        base           = $urandom;
        row.range_high = base;
        row.range_low  = base + int'($urandom_range(1, 1 << 20));
      end
      default: begin
        base           = int'($urandom_range(0, 200 << 16)) - (100 << 16);
        row.range_low  = base;
        row.range_high = base + int'($urandom_range(0, 50 << 16));
      end
    endcase
    return row;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS) begin
      $display("[%0t] MISMATCH: %s", $realtime, what);
    end
  endtask

  // Offer one request, hold it until the block takes it, then record the
  // expected result. Enter and leave at a falling edge.
  task automatic issue_draw(input stim_row_t row);
    draw_result_t want;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_bus.valid      <= 1'b1;
    req_bus.cmd        <= row.cmd;
    req_bus.range_low  <= row.range_low;
    req_bus.range_high <= row.range_high;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    want = predict_draw(row.cmd, row.range_low, row.range_high);
    if (row.pin_draw) begin
      want.raw  = row.pinned.raw;
      want.frac = row.pinned.frac;
    end
    if (row.pin_range) begin
      want.scaled = row.pinned.scaled;
      want.err    = row.pinned.err;
    end
    pending_draws.push_back(want);
    @(negedge clk_i);
  endtask

  task automatic run_random_draws(input int count);
    for (int n = 0; n < count; n++) begin
      issue_draw(random_row());
    end
  endtask

  // Drop valid, wait for every expected result, then let the block settle.
  task automatic wait_drained();
    req_bus.valid <= 1'b0;
    while (pending_draws.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // APB write: setup, access, register written at the edge with pready high.
  task automatic write_seed(input logic [ApbAddrWidth-1:0] addr, input logic [63:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (addr == SEED_LOW_ADDR) begin
      seed_lo_q = value;
    end else begin
      seed_hi_q = value;
    end
    reload_words();
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // APB read of a seed register, compared with the model's copy.
  task automatic check_seed(input logic [ApbAddrWidth-1:0] addr);
    logic [63:0] want;
    want = (addr == SEED_LOW_ADDR) ? seed_lo_q : seed_hi_q;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== want) begin
      flag_mismatch($sformatf("seed read at 0x%0h: got %h, want %h", addr, prdata, want));
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Result side: drop ready at random, or hold it low while a stall is pending.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      rsp_bus.ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Compare each result transaction with the oldest expected draw.
  always @(posedge clk_i) begin : check_results
    draw_result_t want;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_draws.size() == 0) begin
        flag_mismatch("result transaction with no draw pending");
      end else begin
        want = pending_draws.pop_front();
        if (rsp_bus.raw_value !== want.raw) begin
          flag_mismatch($sformatf("raw_value got %h, want %h", rsp_bus.raw_value, want.raw));
        end
        if (rsp_bus.scaled_value !== want.scaled) begin
          flag_mismatch($sformatf("scaled_value got %h, want %h",
                                  rsp_bus.scaled_value, want.scaled));
        end
        if (rsp_bus.unit_fraction !== want.frac) begin
          flag_mismatch($sformatf("unit_fraction got %h, want %h",
                                  rsp_bus.unit_fraction, want.frac));
        end
        if (rsp_bus.span_error !== want.err) begin
          flag_mismatch($sformatf("span_error got %b, want %b", rsp_bus.span_error, want.err));
        end
      end
    end
  end

  // Hard stop well past the slowest correct run.
  initial begin
    #(20_000_000);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    // Drive every input to a known value before the first edge.
    rst_ni             = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    req_bus.valid      = 1'b0;
    req_bus.cmd        = CmdRaw;
    req_bus.range_low  = '0;
    req_bus.range_high = '0;
    rsp_bus.ready      = 1'b0;
    mismatch_count     = 0;
    stall_left         = 0;
    send_idle_pct      = 17;
    recv_idle_pct      = 77;
    seed_lo_q          = SeedLowReset;
    seed_hi_q          = SeedHighReset;
    reload_words();

    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset seeds read back, then the directed draws and a first random batch
    // with a slow receiver.
    check_seed(SEED_LOW_ADDR);
    check_seed(SEED_HIGH_ADDR);
    for (int i = 0; i < NUM_ROWS; i++) begin
      issue_draw(directed_rows[i]);
    end
    run_random_draws(250);
    wait_drained();

    // Zero the low seed alone: the high word still seeds, no fill word yet.
    write_seed(SEED_LOW_ADDR, 64'd0);
    check_seed(SEED_LOW_ADDR);
    run_random_draws(100);
    wait_drained();

    // Both seeds zero: the fill word takes over. Swap the idling sides.
    write_seed(SEED_HIGH_ADDR, 64'd0);
    check_seed(SEED_HIGH_ADDR);
    send_idle_pct = 77;
    recv_idle_pct = 17;
    run_random_draws(350);
    wait_drained();

    // All-ones seeds.
    write_seed(SEED_LOW_ADDR, '1);
    write_seed(SEED_HIGH_ADDR, '1);
    check_seed(SEED_LOW_ADDR);
    check_seed(SEED_HIGH_ADDR);
    run_random_draws(400);
    wait_drained();

    // Random seeds, no idling on either side. Hold the result side off at the
    // start so the output register fills and the request side backs up.
    write_seed(SEED_HIGH_ADDR, {$urandom, $urandom});
    write_seed(SEED_LOW_ADDR, {$urandom, $urandom});
    check_seed(SEED_LOW_ADDR);
    check_seed(SEED_HIGH_ADDR);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_left    = 400;
    run_random_draws(750);
    wait_drained();

    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
